// ===== rtl/extent_range_allocator_assert.svh =====
// Assertion macros used by the allocator top module
`ifndef EXTENT_RANGE_ALLOCATOR_ASSERT_SVH
`define EXTENT_RANGE_ALLOCATOR_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle
`define ERA_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define ERA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/era_pkg.sv =====
package era_pkg;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned IDX_W = 20;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_RESERVE = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_INS   = 2'd2,
    CMD_DEL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_APPLY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [LEN_W-1:0] run_length;
    logic [IDX_W-1:0] base_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] alloc_base;
  } out_item_t;

  localparam logic [0:0] REG_TOTAL = 1'b0;
  localparam logic [0:0] REG_ALIGN = 1'b1;
endpackage

// ===== rtl/era_cell.sv =====
// One table entry: holds an extent, evaluates the request against it and
// shifts with its neighbors on insert or delete.
module era_cell import era_pkg::*; #(
  parameter int unsigned IW = 20,
  parameter int unsigned PW = 4
) (
  input  logic          clk,
  input  logic [PW-1:0] pos,
  input  logic          init,
  input  logic [IW-1:0] init_last,
  input  logic [IW:0]   q_base,
  input  logic [IW:0]   q_endl,
  input  logic [IW:0]   amask,
  input  logic          cap_en,
  input  cmd_t          cmd,
  input  logic [PW-1:0] cmd_pos,
  input  logic [IW-1:0] w_first,
  input  logic [IW-1:0] w_last,
  input  logic          w_second,
  input  logic [IW-1:0] w2_first,
  input  logic [IW-1:0] prev_first,
  input  logic [IW-1:0] prev_last,
  input  logic [IW-1:0] next_first,
  input  logic [IW-1:0] next_last,
  output logic [IW-1:0] first_o,
  output logic [IW-1:0] last_o,
  output logic          f_le_base,
  output logic          holds,
  output logic          fits_o,
  output logic          exact_o,
  output logic [IW:0]   start_o
) ;
  logic [IW-1:0] first_r, last_r;
  logic [IW:0]   start_r;
  logic          f_le_r, holds_r, fits_r, exact_r;
  logic [IW+1:0] st_c;
  logic [IW:0]   start_c;
  logic [IW+1:0] need;

  // round start up, compare with run end inside the extent
  assign st_c    = {2'b0, first_r} + {1'b0, amask};
  assign start_c = st_c[IW:0] & ~amask;
  assign need    = {1'b0, start_c} + {1'b0, q_endl};

  always_ff @(posedge clk) begin
    if (cap_en) begin
      f_le_r  <= ({1'b0, first_r} <= q_base);
      holds_r <= (q_base >= {1'b0, first_r}) && (q_endl <= {1'b0, last_r});
      start_r <= start_c;
      fits_r  <= !st_c[IW+1] && (need <= {2'b0, last_r});
      exact_r <= (need == {2'b0, last_r});
    end
  end

  // shift or overwrite the entry
  always_ff @(posedge clk) begin
    if (init) begin
      first_r <= '0;
      last_r  <= (pos == '0) ? init_last : '0;
    end else begin
      unique case (cmd)
        CMD_WRITE: begin
          if (pos == cmd_pos) begin
            first_r <= w_first;
            last_r  <= w_last;
          end
        end
        CMD_INS: begin
          if (pos == cmd_pos) begin
            first_r <= w_first;
            last_r  <= w_last;
          end else if (w_second && pos == cmd_pos + PW'(1)) begin
            first_r <= w2_first;
            last_r  <= prev_last;
          end else if (pos > cmd_pos) begin
            first_r <= prev_first;
            last_r  <= prev_last;
          end
        end
        CMD_DEL: begin
          if (pos >= cmd_pos) begin
            first_r <= next_first;
            last_r  <= next_last;
          end
        end
        CMD_NONE: ;
        default: ;
      endcase
    end
  end

  assign first_o   = first_r;
  assign last_o    = last_r;
  assign f_le_base = f_le_r;
  assign holds     = holds_r;
  assign fits_o    = fits_r;
  assign exact_o   = exact_r;
  assign start_o   = start_r;
endmodule

// ===== rtl/extent_range_allocator.sv =====
// Extent range allocator: first-fit allocation over a sorted table of free
// extents held in a row of cells.
// Input channel in_valid/in_ready carries one request item (func, run
// length, base index); out_valid/out_ready returns one status item per
// request. After a request is accepted, the cells compare in parallel
// (S_EVAL), a priority search over the row picks the entry (S_DECIDE),
// and one shift step of the row applies the insert, delete or rewrite
// (S_APPLY); a release that merges with both neighbors then rewrites the
// left extent in S_OUT. The block works on one item at a time; the next
// is taken once the block is idle and the result register is free.
// Reset (rst_n low, synchronous) restores one free extent over the whole
// space of 2^IDX_W entries and zero alignment. A write of
// total_entries rebuilds that single extent at once. While the receiver
// stalls, the result stays in its register and no new item is taken.
// The APB port at cfg_ is always ready; register 0 is total_entries,
// register 1 alignment_log2, both readable.
module extent_range_allocator import era_pkg::*; #(
  parameter int unsigned MAX_EXTENTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  `include "extent_range_allocator_assert.svh"

  localparam int unsigned IW = IDX_W;
  localparam int unsigned PW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned UW = $clog2(MAX_EXTENTS + 1);
  localparam logic [UW-1:0] UMAX = UW'(MAX_EXTENTS);
  localparam logic [LEN_W-1:0] SPACE_MAX = LEN_W'(1) << IW;

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] total_r;
  logic [4:0]       align_r;
  logic [UW-1:0]    used_r, used_nxt;
  in_item_t         req_r;
  out_item_t        res_r;
  logic             out_valid_r;
  logic [IW:0]      q_base_r, q_endl_r, amask_r;

  // decision registers
  cmd_t          cmd_r;
  logic [PW-1:0] cmd_pos_r;
  logic [IW-1:0] w_first_r, w_last_r, w2_first_r;
  logic          w_second_r;
  logic [1:0]    dst_r;
  logic [IW-1:0] grant_r;
  logic          merge2_r;
  logic [IW-1:0] merge_last_r;

  logic cfg_wr, init;
  logic [LEN_W-1:0] wtot, space;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign wtot = cfg_pwdata[LEN_W-1:0];

  // clamp space and set up the single extent on reset or total write
  always_comb begin
    space = (cfg_wr && cfg_paddr[2] == REG_TOTAL) ? wtot : total_r;
    if (!rst_n) space = SPACE_MAX;
    if (space == '0) space = LEN_W'(1);
    if (space > SPACE_MAX) space = SPACE_MAX;
  end
  assign init = !rst_n || (cfg_wr && cfg_paddr[2] == REG_TOTAL);

  logic [LEN_W-1:0] space_r;
  always_ff @(posedge clk) begin
    if (init) space_r <= space;
  end

  // row of cells
  logic [IW-1:0] c_first [MAX_EXTENTS];
  logic [IW-1:0] c_last  [MAX_EXTENTS];
  logic [IW:0]   c_start [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] c_fle, c_holds, c_fits, c_exact, c_valid;

  for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
    logic [IW-1:0] pf, pl, nf, nl;
    if (g == 0) begin : g_p0
      assign pf = '0;
      assign pl = '0;
    end else begin : g_pn
      assign pf = c_first[g-1];
      assign pl = c_last[g-1];
    end
    if (g == MAX_EXTENTS - 1) begin : g_nl
      assign nf = '0;
      assign nl = '0;
    end else begin : g_nn
      assign nf = c_first[g+1];
      assign nl = c_last[g+1];
    end
    assign c_valid[g] = (UW'(g) < used_r);
    era_cell #(.IW(IW), .PW(PW)) u_cell (
      .clk(clk), .pos(PW'(g)), .init(init),
      .init_last(IW'(space - LEN_W'(1))),
      .q_base(q_base_r), .q_endl(q_endl_r), .amask(amask_r),
      .cap_en(state_r == S_EVAL),
      .cmd((state_r == S_APPLY || state_r == S_OUT) ? cmd_r : CMD_NONE),
      .cmd_pos(cmd_pos_r),
      .w_first(w_first_r), .w_last(w_last_r), .w_second(w_second_r),
      .w2_first(w2_first_r),
      .prev_first(pf), .prev_last(pl), .next_first(nf), .next_last(nl),
      .first_o(c_first[g]), .last_o(c_last[g]), .f_le_base(c_fle[g]),
      .holds(c_holds[g]), .fits_o(c_fits[g]), .exact_o(c_exact[g]),
      .start_o(c_start[g])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= SPACE_MAX;
      align_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TOTAL) total_r <= wtot;
      else align_r <= cfg_pwdata[4:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_TOTAL) ? 32'(total_r) : 32'(align_r);

  // request decode and query setup
  logic fire_in, fire_out;
  logic [IW+1:0] endl_sum;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign fire_in  = in_valid && in_ready;
  assign fire_out = out_valid_r && out_ready;
  assign endl_sum = {2'b0, in_data.base_index} + {1'b0, in_data.run_length}
                  - (IW+2)'(1);

  always_ff @(posedge clk) begin
    if (fire_in) begin
      req_r    <= in_data;
      q_base_r <= {1'b0, in_data.base_index};
      if (in_data.func == FN_ALLOC)
        q_endl_r <= (IW+1)'(in_data.run_length - LEN_W'(1));
      else
        q_endl_r <= endl_sum[IW+1] ? {(IW+1){1'b1}} : endl_sum[IW:0];
      amask_r  <= (align_r > 5'(IW)) ? {(IW+1){1'b1}}
                : (IW+1)'(((IW+2)'(1) << align_r) - (IW+2)'(1));
    end
  end

  // priority picks over the row
  logic [PW-1:0] fit_i, hold_i, p_i;
  logic          any_fit, any_hold;
  logic [UW-1:0] p_cnt;
  always_comb begin
    fit_i = '0; hold_i = '0; any_fit = 1'b0; any_hold = 1'b0; p_cnt = '0;
    for (int k = MAX_EXTENTS - 1; k >= 0; k--) begin
      if (c_valid[k] && c_fits[k]) begin fit_i = PW'(k); any_fit = 1'b1; end
      if (c_valid[k] && c_holds[k]) begin hold_i = PW'(k); any_hold = 1'b1; end
    end
    for (int k = 0; k < MAX_EXTENTS; k++)
      if (c_valid[k] && c_fle[k]) p_cnt = UW'(k + 1);
    p_i = PW'(p_cnt);
  end

  // decide the table change
  logic [LEN_W-1:0] rlen;
  logic [IW+1:0]    rend;
  logic [IW-1:0]    ff, fl, pm_last, pn_first, hf, hl;
  logic [IW:0]      fst;
  logic             full, mp, mn, has_p, has_n;
  assign rlen = req_r.run_length;
  assign rend = {2'b0, req_r.base_index} + {1'b0, rlen};
  assign full = (used_r >= UMAX);
  assign ff = c_first[fit_i];
  assign fl = c_last[fit_i];
  assign fst = c_start[fit_i];
  assign hf = c_first[hold_i];
  assign hl = c_last[hold_i];
  assign has_p = (p_cnt != '0);
  assign has_n = (p_cnt < used_r);
  assign pm_last  = c_last[PW'(p_cnt - UW'(1))];
  assign pn_first = c_first[p_i];
  assign mp = has_p && ({1'b0, pm_last} + (IW+1)'(1) == (IW+1)'(req_r.base_index));
  assign mn = has_n && ({2'b0, pn_first} == rend);

  cmd_t          cmd_c;
  logic [PW-1:0] pos_c;
  logic [IW-1:0] wf_c, wl_c, w2_c, gr_c;
  logic          ws_c;
  logic [1:0]    st_c;
  logic [UW-1:0] un_c;
  always_comb begin
    cmd_c = CMD_NONE; pos_c = '0; wf_c = '0; wl_c = '0; w2_c = '0;
    ws_c = 1'b0; st_c = ST_OK; gr_c = '0; un_c = used_r;
    unique case (func_t'(req_r.func))
      FN_ALLOC: begin
        if (rlen == '0 || !any_fit) st_c = ST_NOFIT;
        else if (!c_exact[fit_i]) begin
          if (fst > {1'b0, ff}) begin
            if (full) st_c = ST_FULL;
            else begin
              cmd_c = CMD_INS; pos_c = fit_i; wf_c = ff; wl_c = IW'(fst - 1'b1);
              ws_c = 1'b1; w2_c = IW'(fst + rlen); un_c = used_r + UW'(1);
              gr_c = IW'(fst);
            end
          end else begin
            cmd_c = CMD_WRITE; pos_c = fit_i; wf_c = IW'(fst + rlen); wl_c = fl;
            gr_c = IW'(fst);
          end
        end else begin
          gr_c = IW'(fst);
          if (fst > {1'b0, ff}) begin
            cmd_c = CMD_WRITE; pos_c = fit_i; wf_c = ff; wl_c = IW'(fst - 1'b1);
          end else begin
            cmd_c = CMD_DEL; pos_c = fit_i; un_c = used_r - UW'(1);
          end
        end
      end
      FN_RELEASE: begin
        if (rlen == '0) st_c = ST_OK;
        else if (rend > {1'b0, space_r}) st_c = ST_NOTFREE;
        else if (has_p && pm_last >= req_r.base_index) st_c = ST_NOTFREE;
        else if (has_n && {2'b0, pn_first} < rend) st_c = ST_NOTFREE;
        else if (mp && mn) begin
          cmd_c = CMD_DEL; pos_c = p_i; un_c = used_r - UW'(1);
          ws_c = 1'b1;
        end else if (mp) begin
          cmd_c = CMD_WRITE; pos_c = PW'(p_cnt - UW'(1));
          wf_c = c_first[PW'(p_cnt - UW'(1))]; wl_c = IW'(rend - 1'b1);
        end else if (mn) begin
          cmd_c = CMD_WRITE; pos_c = p_i; wf_c = req_r.base_index;
          wl_c = c_last[p_i];
        end else if (full) st_c = ST_FULL;
        else begin
          cmd_c = CMD_INS; pos_c = p_i; wf_c = req_r.base_index;
          wl_c = IW'(rend - 1'b1); un_c = used_r + UW'(1);
        end
      end
      FN_RESERVE: begin
        if (rlen == '0) st_c = ST_OK;
        else if (!any_hold) st_c = ST_NOTFREE;
        else if (req_r.base_index == hf) begin
          if (q_endl_r == {1'b0, hl}) begin
            cmd_c = CMD_DEL; pos_c = hold_i; un_c = used_r - UW'(1);
          end else begin
            cmd_c = CMD_WRITE; pos_c = hold_i; wf_c = IW'(q_endl_r + 1'b1); wl_c = hl;
          end
        end else if (q_endl_r < {1'b0, hl}) begin
          if (full) st_c = ST_FULL;
          else begin
            cmd_c = CMD_INS; pos_c = hold_i; wf_c = hf;
            wl_c = req_r.base_index - IW'(1);
            ws_c = 1'b1; w2_c = IW'(q_endl_r + 1'b1); un_c = used_r + UW'(1);
          end
        end else begin
          cmd_c = CMD_WRITE; pos_c = hold_i; wf_c = hf;
          wl_c = req_r.base_index - IW'(1);
        end
      end
      FN_NONE: st_c = ST_OK;
      default: st_c = ST_OK;
    endcase
  end

  // latch the decision; merge-both then rewrites the left extent with the
  // right's last on the next cycle, after the right one is deleted
  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      cmd_r <= cmd_c; cmd_pos_r <= pos_c; w_first_r <= wf_c; w_last_r <= wl_c;
      w2_first_r <= w2_c; w_second_r <= ws_c && (cmd_c == CMD_INS);
      dst_r <= st_c; grant_r <= gr_c;
      merge2_r     <= (cmd_c == CMD_DEL) && ws_c;
      merge_last_r <= c_last[p_i];
    end else if (state_r == S_APPLY && merge2_r) begin
      cmd_r      <= CMD_WRITE;
      cmd_pos_r  <= cmd_pos_r - PW'(1);
      w_first_r  <= c_first[cmd_pos_r - PW'(1)];
      w_last_r   <= merge_last_r;
      w_second_r <= 1'b0;
      merge2_r   <= 1'b0;
    end
  end

  // table size
  always_comb begin
    used_nxt = used_r;
    if (state_r == S_DECIDE) used_nxt = un_c;
  end

  always_ff @(posedge clk) begin
    if (init) used_r <= UW'(1);
    else used_r <= used_nxt;
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (fire_in) state_nxt = S_EVAL;
      S_EVAL:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_APPLY;
      S_APPLY:  state_nxt = merge2_r ? S_OUT : S_IDLE;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // result write enable for merge-both, issued in S_OUT
  logic fix_we;
  always_comb begin
    fix_we = (state_r == S_OUT);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == S_APPLY && !merge2_r) out_valid_r <= 1'b1;
    else if (fix_we) out_valid_r <= 1'b1;
    else if (fire_out) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_APPLY && !merge2_r) || fix_we) begin
      res_r.status     <= dst_r;
      res_r.alloc_base <= (dst_r == ST_OK) ? grant_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `ERA_ASSERT_SAME(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `ERA_ASSERT_NEXT(a_eval_after_accept, clk, rst_n, fire_in, state_r == S_EVAL)
  `ERA_ASSERT_SAME(a_used_bound, clk, rst_n, 1'b1, used_r <= UMAX)
  `ERA_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid_r && !out_ready,
                   out_valid_r && $stable(res_r))
endmodule

// ===== tb/extent_range_allocator_test.sv =====
module extent_range_allocator_test;
  import era_pkg::*;

  localparam int unsigned NUM_EXT = 16;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_psel;
  logic       cfg_penable;
  logic       cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic       cfg_pready;

  extent_range_allocator #(.MAX_EXTENTS(NUM_EXT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Free-extent table mirror, widened to 64 bits so sums never wrap
  longint unsigned free_first [NUM_EXT];
  longint unsigned free_last [NUM_EXT];
  int unsigned     free_count;
  logic [20:0]     space_reg;
  logic [4:0]      align_reg;

  out_item_t  pending_results [$];
  int unsigned error_count;
  longint unsigned cycle_count;
  bit         stall_armed;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic longint unsigned space_entries();
    longint unsigned t;
    t = space_reg;
    if (t == 0) t = 1;
    if (t > (64'd1 << IDX_W)) t = 64'd1 << IDX_W;
    return t;
  endfunction

  function automatic void rebuild_table();
    for (int k = 0; k < NUM_EXT; k++) begin
      free_first[k] = 0;
      free_last[k] = 0;
    end
    free_last[0] = space_entries() - 1;
    free_count = 1;
  endfunction

  function automatic void open_slot(int unsigned pos, longint unsigned f,
                                    longint unsigned l);
    for (int k = int'(free_count); k > int'(pos); k--) begin
      free_first[k] = free_first[k-1];
      free_last[k] = free_last[k-1];
    end
    free_first[pos] = f;
    free_last[pos] = l;
    free_count++;
  endfunction

  function automatic void close_slot(int unsigned pos);
    for (int k = int'(pos); k < int'(free_count) - 1; k++) begin
      free_first[k] = free_first[k+1];
      free_last[k] = free_last[k+1];
    end
    free_count--;
    free_first[free_count] = 0;
    free_last[free_count] = 0;
  endfunction

  function automatic status_t try_allocate(longint unsigned len,
                                           output longint unsigned grant);
    longint unsigned step;
    longint unsigned f;
    longint unsigned l;
    longint unsigned start;
    longint unsigned avail;
    grant = 0;
    step = 64'd1 << align_reg;
    if (len == 0) return ST_NOFIT;
    for (int unsigned k = 0; k < free_count; k++) begin
      f = free_first[k];
      l = free_last[k];
      start = (f + step - 1) & ~(step - 1);
      if (start > l) continue;
      avail = l - start + 1;
      if (len < avail) begin
        if (start > f) begin
          if (free_count >= NUM_EXT) return ST_FULL;
          open_slot(k, f, start - 1);
          free_first[k+1] = start + len;
        end else begin
          free_first[k] = start + len;
        end
        grant = start;
        return ST_OK;
      end
      if (len == avail) begin
        if (start > f) free_last[k] = start - 1;
        else close_slot(k);
        grant = start;
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  function automatic status_t try_release(longint unsigned base,
                                          longint unsigned len);
    longint unsigned stop;
    int unsigned p;
    bit join_prev;
    bit join_next;
    stop = base + len;
    p = 0;
    if (len == 0) return ST_OK;
    if (stop > space_entries()) return ST_NOTFREE;
    while (p < free_count && free_first[p] <= base) p++;
    if (p > 0 && free_last[p-1] >= base) return ST_NOTFREE;
    if (p < free_count && free_first[p] < stop) return ST_NOTFREE;
    join_prev = (p > 0 && free_last[p-1] + 1 == base);
    join_next = (p < free_count && free_first[p] == stop);
    if (join_prev && join_next) begin
      free_last[p-1] = free_last[p];
      close_slot(p);
    end else if (join_prev) begin
      free_last[p-1] = stop - 1;
    end else if (join_next) begin
      free_first[p] = base;
    end else begin
      if (free_count >= NUM_EXT) return ST_FULL;
      open_slot(p, base, stop - 1);
    end
    return ST_OK;
  endfunction

  function automatic status_t try_reserve(longint unsigned base,
                                          longint unsigned len);
    longint unsigned tail;
    int unsigned k;
    tail = base + len - 1;
    if (len == 0) return ST_OK;
    for (k = 0; k < free_count; k++)
      if (base >= free_first[k] && tail <= free_last[k]) break;
    if (k == free_count) return ST_NOTFREE;
    if (base == free_first[k]) begin
      if (tail == free_last[k]) close_slot(k);
      else free_first[k] = tail + 1;
    end else if (tail < free_last[k]) begin
      if (free_count >= NUM_EXT) return ST_FULL;
      open_slot(k + 1, tail + 1, free_last[k]);
      free_last[k] = base - 1;
    end else begin
      free_last[k] = base - 1;
    end
    return ST_OK;
  endfunction

  function automatic out_item_t predict_grant(in_item_t req);
    out_item_t res;
    longint unsigned grant;
    status_t st;
    grant = 0;
    st = ST_OK;
    case (func_t'(req.func))
      FN_ALLOC: begin
        st = try_allocate(req.run_length, grant);
        if (st != ST_OK) grant = 0;
      end
      FN_RELEASE: st = try_release(req.base_index, req.run_length);
      FN_RESERVE: st = try_reserve(req.base_index, req.run_length);
      default: st = ST_OK;
    endcase
    res.status = st;
    res.alloc_base = grant[IDX_W-1:0];
    return res;
  endfunction

  // Register write: setup cycle then access cycle
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_TOTAL) begin
      space_reg = value[20:0];
      rebuild_table();
    end else begin
      align_reg = value[4:0];
    end
  endtask

  // Offer one item, hold until accepted, then queue its expected result
  task automatic send_item(in_item_t req, int unsigned gap);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_grant(req));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Compare each returned item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        error_count++;
      end else begin
        out_item_t exp_item;
        exp_item = pending_results.pop_front();
        if (out_data.status !== exp_item.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_item.status, out_data.status);
          error_count++;
        end
        if (out_data.alloc_base !== exp_item.alloc_base) begin
          $display("%0t: alloc_base expected %h actual %h", $time,
                   exp_item.alloc_base, out_data.alloc_base);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_armed) begin
        stall_armed = 1'b0;
        out_ready <= 1'b0;
        hold = 300;
        while (hold != 0) begin
          @(posedge clk);
          hold--;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  typedef struct {
    func_t               fn;
    longint unsigned     len;
    longint unsigned     base;
    bit                  typed_in;
    status_t             want_status;
    longint unsigned     want_base;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic stim_row_t row(func_t fn, longint unsigned len,
                                    longint unsigned base, bit typed_in,
                                    status_t st, longint unsigned wb);
    stim_row_t r;
    r.fn = fn; r.len = len; r.base = base; r.typed_in = typed_in;
    r.want_status = st; r.want_base = wb;
    return r;
  endfunction

  function automatic in_item_t make_item(func_t fn, longint unsigned len,
                                         longint unsigned base);
    in_item_t it;
    it.func = fn;
    it.run_length = len[LEN_W-1:0];
    it.base_index = base[IDX_W-1:0];
    return it;
  endfunction

  // Random request biased toward the live table
  function automatic in_item_t random_request(int unsigned big);
    func_t fn;
    longint unsigned len;
    longint unsigned base;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 38) fn = FN_ALLOC;
    else if (pick < 68) fn = FN_RELEASE;
    else if (pick < 96) fn = FN_RESERVE;
    else fn = FN_NONE;
    len = (big != 0) ? $urandom_range(0, 2097151) : $urandom_range(0, 40);
    base = $urandom_range(0, 1048575);
    if (big == 0) base = base % (space_entries() + 8);
    if (free_count != 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, free_count - 1);
      case ($urandom_range(0, 3))
        0: base = free_first[k];
        1: base = free_last[k] + 1;
        2: base = (free_first[k] > 0) ? free_first[k] - len : 0;
        default: base = free_first[k] + $urandom_range(0, 3);
      endcase
      if (fn == FN_RESERVE && $urandom_range(0, 1) == 0 &&
          free_last[k] >= base)
        len = $urandom_range(0, 1) ? free_last[k] - base + 1 :
              $urandom_range(1, 8);
    end
    return make_item(fn, len, base & 64'hFFFFF);
  endfunction

  initial begin
    in_item_t req;
    out_item_t want;
    stim_row_t r;
    int unsigned sent;
    int unsigned burst;
    int unsigned big;
    error_count = 0;
    stall_armed = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    space_reg = 21'd1048576;
    align_reg = 5'd0;
    rebuild_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every request, special cases
    directed_rows.push_back(row(FN_ALLOC, 0, 0, 1, ST_NOFIT, 0));
    directed_rows.push_back(row(FN_ALLOC, 1, 0, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_ALLOC, 1048576, 0, 1, ST_NOFIT, 0));
    directed_rows.push_back(row(FN_RELEASE, 1, 0, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_RELEASE, 1, 0, 1, ST_NOTFREE, 0));
    directed_rows.push_back(row(FN_RELEASE, 2097151, 1048575, 1, ST_NOTFREE, 0));
    directed_rows.push_back(row(FN_RELEASE, 0, 5, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_RESERVE, 0, 5, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_NONE, 2097151, 1048575, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_ALLOC, 1048576, 0, 1, ST_OK, 0));
    directed_rows.push_back(row(FN_ALLOC, 1, 0, 1, ST_NOFIT, 0));
    directed_rows.push_back(row(FN_RESERVE, 1, 0, 1, ST_NOTFREE, 0));
    directed_rows.push_back(row(FN_RELEASE, 10, 100, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RELEASE, 10, 110, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RELEASE, 10, 90, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RELEASE, 5, 200, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RELEASE, 95, 105, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RESERVE, 3, 95, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RESERVE, 2, 203, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_RESERVE, 50, 100, 0, ST_OK, 0));
    directed_rows.push_back(row(FN_ALLOC, 7, 0, 0, ST_OK, 0));
    for (int k = 0; k < 8; k++)
      directed_rows.push_back(row(FN_RELEASE, 1, 1000 + 2 * k, 0, ST_OK, 0));

    foreach (directed_rows[n]) begin
      r = directed_rows[n];
      req = make_item(r.fn, r.len, r.base);
      if (r.typed_in) begin
        want.status = r.want_status;
        want.alloc_base = r.want_base[IDX_W-1:0];
        send_item(req, 0);
        void'(pending_results.pop_back());
        pending_results.push_back(want);
      end else begin
        send_item(req, $urandom_range(0, 2));
      end
    end
    drop_valid();
    wait_drained();

    // Full table and large alignment on a small space
    write_reg(REG_TOTAL, 32'd64);
    write_reg(REG_ALIGN, 32'd31);
    send_item(make_item(FN_ALLOC, 1, 0), 0);
    drop_valid();
    wait_drained();
    write_reg(REG_ALIGN, 32'd3);
    for (int k = 0; k < 17; k++)
      send_item(make_item(FN_RESERVE, 1, 2 + 3 * k), 0);
    send_item(make_item(FN_ALLOC, 1, 0), 0);
    send_item(make_item(FN_RELEASE, 1, 62), 0);
    drop_valid();
    wait_drained();

    // Random phases across several settings
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_TOTAL, 32'd1); write_reg(REG_ALIGN, 32'd0); end
        1: begin write_reg(REG_TOTAL, 32'd0); write_reg(REG_ALIGN, 32'd16); end
        2: begin write_reg(REG_TOTAL, 32'd200); write_reg(REG_ALIGN, 32'd1); end
        3: begin write_reg(REG_TOTAL, 32'h1FFFFF); write_reg(REG_ALIGN, 32'd0); end
        4: begin write_reg(REG_TOTAL, 32'd1048576); write_reg(REG_ALIGN, 32'd17); end
        5: begin write_reg(REG_TOTAL, 32'd333); write_reg(REG_ALIGN, 32'd2); end
        6: begin write_reg(REG_TOTAL, 32'd97); write_reg(REG_ALIGN, 32'd0); end
        default: begin
          write_reg(REG_TOTAL, $urandom_range(1, 1048576));
          write_reg(REG_ALIGN, $urandom_range(0, 31));
        end
      endcase
      if (phase == 5) stall_armed = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        big = (phase == 3 || phase == 4 || $urandom_range(0, 19) == 0);
        req = random_request(big);
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        if (burst != 0) drop_valid();
        send_item(req, burst);
        sent++;
      end
      drop_valid();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
